// ===== hw/rtl/ddrc_pkg.sv =====
// Package for the differential drive ramp controller.
// Holds the item codes, register indexes, reset values and the shared structs.
// No dependencies.
package ddrc_pkg;

    localparam logic [1:0] KIND_ORDER  = 2'd0;
    localparam logic [1:0] KIND_TICK   = 2'd1;
    localparam logic [1:0] KIND_LOCK   = 2'd2;
    localparam logic [1:0] KIND_UNLOCK = 2'd3;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SPEED_MAX        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_SPEED       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORDER_TIMEOUT_MS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_INTERVAL_MS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_RATE       = 3'd4;

    localparam logic [7:0]  RST_SPEED_MAX        = 8'd255;
    localparam logic [7:0]  RST_TURN_SPEED       = 8'd128;
    localparam logic [15:0] RST_ORDER_TIMEOUT_MS = 16'd500;
    localparam logic [15:0] RST_RAMP_INTERVAL_MS = 16'd100;
    localparam logic [15:0] RST_ACCEL_RATE       = 16'd1671;

    localparam logic [1:0] DIR_STBY = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_BACK = 2'd2;

    localparam logic [2:0] OP_FWD    = 3'd0;
    localparam logic [2:0] OP_REV    = 3'd1;
    localparam logic [2:0] OP_TURN_R = 3'd2;
    localparam logic [2:0] OP_TURN_L = 3'd3;
    localparam logic [2:0] OP_TICK   = 3'd4;
    localparam logic [2:0] OP_LOCK   = 3'd5;

    localparam logic [7:0] STICK_HIGH   = 8'd150;
    localparam logic [7:0] STICK_LOW    = 8'd100;
    localparam logic [7:0] STICK_CENTRE = 8'd127;

    localparam int GAIN_W = 9;
    localparam logic [GAIN_W-1:0] GAIN_MAX = '1;

    typedef struct packed {
        logic [7:0]  speed_max;
        logic [7:0]  turn_speed;
        logic [15:0] order_timeout_ms;
        logic [15:0] ramp_interval_ms;
        logic [15:0] accel_rate;
    } t_cfg;

    typedef struct packed {
        logic [2:0]        op;
        logic              tmo;
        logic              rmp;
        logic [15:0]       prod;
        logic [GAIN_W-1:0] gain;
    } t_cmd;

    typedef struct packed {
        logic [1:0] right_dir;
        logic [7:0] right_duty;
        logic [1:0] left_dir;
        logic [7:0] left_duty;
        logic       last;
    } t_result;

    localparam t_result RES_STANDBY = '{
        right_dir:  DIR_STBY,
        right_duty: 8'd0,
        left_dir:   DIR_STBY,
        left_duty:  8'd0,
        last:       1'b0
    };

endpackage

// ===== hw/rtl/ddrc_front.sv =====
// Front part: accepts transactions, keeps the lock flag and millisecond counters,
// classifies each item and forms the products the back part needs.
// Depends on ddrc_pkg.
module ddrc_front #(
    parameter int TICK_COUNT_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [1:0]       i_kind,
    input  logic [7:0]       i_forward_stick,
    input  logic [7:0]       i_turn_stick,
    input  ddrc_pkg::t_cfg   i_cfg,
    output logic             o_cmd_push,
    output ddrc_pkg::t_cmd   o_cmd
);
    import ddrc_pkg::*;

    localparam int CW = (TICK_COUNT_BITS > 16) ? TICK_COUNT_BITS : 16;
    localparam int PW = TICK_COUNT_BITS + 16;
    localparam logic [TICK_COUNT_BITS-1:0] CNT_MAX = '1;

    logic                       r_locked, n_locked;
    logic [TICK_COUNT_BITS-1:0] r_since_order, n_since_order;
    logic [TICK_COUNT_BITS-1:0] r_since_ramp, n_since_ramp;

    logic [TICK_COUNT_BITS-1:0] inc_order, inc_ramp, ramp_gain;
    logic [PW-1:0]              ramp_prod;
    logic                       timeout, ramp_now;
    logic                       fwd_high, fwd_low, turn_high, turn_low;
    logic [7:0]                 mul_a;

    assign inc_order = (r_since_order == CNT_MAX) ? r_since_order
                                                  : r_since_order + TICK_COUNT_BITS'(1);
    assign inc_ramp  = (r_since_ramp == CNT_MAX) ? r_since_ramp
                                                 : r_since_ramp + TICK_COUNT_BITS'(1);
    assign timeout   = CW'(inc_order) > CW'(i_cfg.order_timeout_ms);
    assign ramp_now  = CW'(inc_ramp) > CW'(i_cfg.ramp_interval_ms);
    assign ramp_prod = PW'(inc_ramp) * PW'(i_cfg.accel_rate);
    assign ramp_gain = ramp_prod[PW-1:16];

    assign fwd_high  = i_forward_stick > STICK_HIGH;
    assign fwd_low   = i_forward_stick < STICK_LOW;
    assign turn_high = i_turn_stick > STICK_HIGH;
    assign turn_low  = i_turn_stick < STICK_LOW;
    assign mul_a     = fwd_high ? i_forward_stick - STICK_CENTRE : i_forward_stick;

    always_comb begin
        n_locked      = r_locked;
        n_since_order = r_since_order;
        n_since_ramp  = r_since_ramp;
        o_cmd_push    = 1'b0;
        o_cmd.op      = OP_TICK;
        o_cmd.tmo     = timeout;
        o_cmd.rmp     = ramp_now;
        o_cmd.prod    = 16'(mul_a) * 16'(i_cfg.speed_max);
        o_cmd.gain    = (ramp_gain > TICK_COUNT_BITS'(GAIN_MAX)) ? GAIN_MAX
                                                                 : ramp_gain[GAIN_W-1:0];
        if (i_accept) begin
            unique case (i_kind)
                KIND_ORDER: begin
                    n_since_order = '0;
                    if (!r_locked) begin
                        priority if (fwd_high) begin
                            o_cmd_push = 1'b1;
                            o_cmd.op   = OP_FWD;
                        end else if (fwd_low) begin
                            o_cmd_push = 1'b1;
                            o_cmd.op   = OP_REV;
                        end else if (turn_high) begin
                            o_cmd_push = 1'b1;
                            o_cmd.op   = OP_TURN_R;
                        end else if (turn_low) begin
                            o_cmd_push = 1'b1;
                            o_cmd.op   = OP_TURN_L;
                        end else begin
                            o_cmd_push = 1'b0;
                        end
                    end
                end
                KIND_TICK: begin
                    n_since_order = inc_order;
                    n_since_ramp  = ramp_now ? '0 : inc_ramp;
                    o_cmd_push    = timeout | ramp_now;
                    o_cmd.op      = OP_TICK;
                end
                KIND_LOCK: begin
                    n_locked   = 1'b1;
                    o_cmd_push = 1'b1;
                    o_cmd.op   = OP_LOCK;
                end
                KIND_UNLOCK: begin
                    n_locked = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_locked      <= 1'b0;
            r_since_order <= '0;
            r_since_ramp  <= '0;
        end else begin
            r_locked      <= n_locked;
            r_since_order <= n_since_order;
            r_since_ramp  <= n_since_ramp;
        end
    end

endmodule

// ===== hw/rtl/ddrc_cmdq.sv =====
// Two-entry command queue between the front and the back part.
// Depends on ddrc_pkg.
module ddrc_cmdq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ddrc_pkg::t_cmd i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output ddrc_pkg::t_cmd o_data
);
    import ddrc_pkg::*;

    localparam int DEPTH = 2;

    t_cmd       r_mem [DEPTH];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push, do_pop;

    assign o_full  = r_count == 2'(DEPTH);
    assign o_empty = r_count == 2'd0;
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

// ===== hw/rtl/ddrc_back.sv =====
// Back part: applies commands to the wheel targets and speeds and forms results.
// Depends on ddrc_pkg.
module ddrc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  ddrc_pkg::t_cmd    i_cmd,
    output logic              o_cmd_pop,
    input  logic [7:0]        i_turn_speed,
    input  logic              i_out_space2,
    output logic [1:0]        o_push_cnt,
    output ddrc_pkg::t_result o_res0,
    output ddrc_pkg::t_result o_res1
);
    import ddrc_pkg::*;

    localparam logic [7:0] DOUBLE_BELOW = 8'd10;

    logic signed [8:0] r_target_right, n_target_right;
    logic signed [8:0] r_target_left, n_target_left;
    logic signed [8:0] r_speed_right, n_speed_right;
    logic signed [8:0] r_speed_left, n_speed_left;

    function automatic logic [7:0] f_mag(input logic signed [8:0] v);
        logic signed [8:0] neg;
        neg = -v;
        return v[8] ? neg[7:0] : v[7:0];
    endfunction

    function automatic logic signed [8:0] f_ramp(input logic signed [8:0] target,
                                                input logic signed [8:0] speed,
                                                input logic [GAIN_W-1:0] gain);
        logic [7:0]        at, as;
        logic [9:0]        sum;
        logic [7:0]        m;
        logic signed [8:0] r;
        at  = f_mag(target);
        as  = f_mag(speed);
        sum = 10'(as) + 10'(gain);
        m   = (sum > 10'(at)) ? at : sum[7:0];
        if (m < DOUBLE_BELOW) begin
            m = {m[6:0], 1'b0};
        end
        if (target == speed) begin
            r = speed;
        end else if (target == 9'sd0 || as >= at) begin
            r = 9'sd0;
        end else if (target[8]) begin
            r = -$signed({1'b0, m});
        end else begin
            r = $signed({1'b0, m});
        end
        return r;
    endfunction

    function automatic logic [1:0] f_dir(input logic signed [8:0] v);
        logic [1:0] d;
        if (v[8]) begin
            d = DIR_BACK;
        end else if (v != 9'sd0) begin
            d = DIR_FWD;
        end else begin
            d = DIR_STBY;
        end
        return d;
    endfunction

    function automatic t_result f_result(input logic signed [8:0] right,
                                         input logic signed [8:0] left,
                                         input logic last);
        t_result res;
        res.right_dir  = f_dir(right);
        res.right_duty = f_mag(right);
        res.left_dir   = f_dir(left);
        res.left_duty  = f_mag(left);
        res.last       = last;
        return res;
    endfunction

    logic              go;
    logic signed [8:0] fwd_t, rev_t, turn_t;
    logic [25:0]       est;
    logic [9:0]        q0, q;
    logic [16:0]       rem;
    logic signed [8:0] tick_right, tick_left, ramp_right, ramp_left;

    assign go        = i_cmd_valid && i_out_space2;
    assign o_cmd_pop = go;

    assign fwd_t  = $signed({1'b0, i_cmd.prod[14:7]});
    assign est    = 26'({i_cmd.prod, 9'b0}) + 26'({i_cmd.prod, 2'b0});
    assign q0     = est[25:16];
    assign rem    = 17'(i_cmd.prod) - (17'({q0, 7'b0}) - 17'(q0));
    assign q      = (rem >= 17'(STICK_CENTRE)) ? q0 + 10'd1 : q0;
    assign rev_t  = -$signed({1'b0, q[7:0]});
    assign turn_t = $signed({1'b0, i_turn_speed});

    assign tick_right = i_cmd.tmo ? 9'sd0 : r_target_right;
    assign tick_left  = i_cmd.tmo ? 9'sd0 : r_target_left;
    assign ramp_right = f_ramp(tick_right, r_speed_right, i_cmd.gain);
    assign ramp_left  = f_ramp(tick_left, r_speed_left, i_cmd.gain);

    always_comb begin
        n_target_right = r_target_right;
        n_target_left  = r_target_left;
        n_speed_right  = r_speed_right;
        n_speed_left   = r_speed_left;
        o_push_cnt     = 2'd0;
        o_res0         = RES_STANDBY;
        o_res1         = RES_STANDBY;
        if (go) begin
            unique case (i_cmd.op)
                OP_FWD: begin
                    n_target_right = fwd_t;
                    n_target_left  = fwd_t;
                end
                OP_REV: begin
                    n_target_right = rev_t;
                    n_target_left  = rev_t;
                end
                OP_TURN_R: begin
                    n_target_right = -turn_t;
                    n_target_left  = turn_t;
                end
                OP_TURN_L: begin
                    n_target_right = turn_t;
                    n_target_left  = -turn_t;
                end
                OP_LOCK: begin
                    o_push_cnt  = 2'd1;
                    o_res0.last = 1'b1;
                end
                OP_TICK: begin
                    n_target_right = tick_right;
                    n_target_left  = tick_left;
                    if (i_cmd.rmp) begin
                        n_speed_right = ramp_right;
                        n_speed_left  = ramp_left;
                    end
                    priority if (i_cmd.tmo && i_cmd.rmp) begin
                        o_push_cnt = 2'd2;
                        o_res1     = f_result(ramp_right, ramp_left, 1'b1);
                    end else if (i_cmd.tmo) begin
                        o_push_cnt  = 2'd1;
                        o_res0.last = 1'b1;
                    end else begin
                        o_push_cnt = 2'd1;
                        o_res0     = f_result(ramp_right, ramp_left, 1'b1);
                    end
                end
                default: begin
                    o_push_cnt = 2'd0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_right <= 9'sd0;
            r_target_left  <= 9'sd0;
            r_speed_right  <= 9'sd0;
            r_speed_left   <= 9'sd0;
        end else begin
            r_target_right <= n_target_right;
            r_target_left  <= n_target_left;
            r_speed_right  <= n_speed_right;
            r_speed_left   <= n_speed_left;
        end
    end

endmodule

// ===== hw/rtl/ddrc_outq.sv =====
// Four-entry result queue; takes up to two results per cycle, gives one.
// Depends on ddrc_pkg.
module ddrc_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_push_cnt,
    input  ddrc_pkg::t_result i_data0,
    input  ddrc_pkg::t_result i_data1,
    output logic              o_space2,
    input  logic              i_pop,
    output logic              o_empty,
    output ddrc_pkg::t_result o_data
);
    import ddrc_pkg::*;

    localparam int DEPTH = 4;

    t_result    r_mem [DEPTH];
    logic [1:0] r_wr_ptr, r_rd_ptr, wr_ptr1;
    logic [2:0] r_count;
    logic       do_pop;

    assign o_space2 = r_count <= 3'(DEPTH - 2);
    assign o_empty  = r_count == 3'd0;
    assign o_data   = r_mem[r_rd_ptr];
    assign do_pop   = i_pop && !o_empty;
    assign wr_ptr1  = r_wr_ptr + 2'd1;

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_data0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[wr_ptr1] <= i_data1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            r_wr_ptr <= r_wr_ptr + i_push_cnt;
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            r_count <= r_count + 3'(i_push_cnt) - 3'(do_pop);
        end
    end

endmodule

// ===== hw/rtl/differential_drive_ramp_controller_unit.sv =====
// Top level of the differential drive ramp controller: configuration registers,
// front part, command queue, back part and result queue.
// Depends on ddrc_pkg, ddrc_front, ddrc_cmdq, ddrc_back and ddrc_outq.
//
//   Channel   Handshake           Payload
//   input     push / full         i_kind, i_forward_stick, i_turn_stick
//   result    empty / pop         o_right_dir, o_right_duty, o_left_dir,
//                                 o_left_duty, o_last
//   config    i_cfg_wr_en         i_cfg_index, i_cfg_data
//
// One input transaction can be accepted every cycle while full is low. A result
// reaches the result ports only after passing the command and result queues.
// A tick may yield two results, which enter the result queue in the same cycle.
// The back part waits while the result queue has fewer than two free entries;
// full rises once the two-entry command queue is then filled.
// Reset is synchronous and empties both queues.
module differential_drive_ramp_controller_unit #(
    parameter int TICK_COUNT_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic [1:0]                         i_kind,
    input  logic [7:0]                         i_forward_stick,
    input  logic [7:0]                         i_turn_stick,
    output logic                               empty,
    input  logic                               pop,
    output logic [1:0]                         o_right_dir,
    output logic [7:0]                         o_right_duty,
    output logic [1:0]                         o_left_dir,
    output logic [7:0]                         o_left_duty,
    output logic                               o_last,
    input  logic                               i_cfg_wr_en,
    input  logic [ddrc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ddrc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import ddrc_pkg::*;

    t_cfg    r_cfg;
    logic    accept;
    logic    cmd_push, cmd_pop, cmd_empty;
    t_cmd    cmd_in, cmd_out;
    logic    out_space2;
    logic [1:0] push_cnt;
    t_result res0, res1, res_out;

    assign accept = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.speed_max        <= RST_SPEED_MAX;
            r_cfg.turn_speed       <= RST_TURN_SPEED;
            r_cfg.order_timeout_ms <= RST_ORDER_TIMEOUT_MS;
            r_cfg.ramp_interval_ms <= RST_RAMP_INTERVAL_MS;
            r_cfg.accel_rate       <= RST_ACCEL_RATE;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_SPEED_MAX:        r_cfg.speed_max        <= i_cfg_data[7:0];
                REG_TURN_SPEED:       r_cfg.turn_speed       <= i_cfg_data[7:0];
                REG_ORDER_TIMEOUT_MS: r_cfg.order_timeout_ms <= i_cfg_data;
                REG_RAMP_INTERVAL_MS: r_cfg.ramp_interval_ms <= i_cfg_data;
                REG_ACCEL_RATE:       r_cfg.accel_rate       <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    ddrc_front #(
        .TICK_COUNT_BITS(TICK_COUNT_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_kind         (i_kind),
        .i_forward_stick(i_forward_stick),
        .i_turn_stick   (i_turn_stick),
        .i_cfg          (r_cfg),
        .o_cmd_push     (cmd_push),
        .o_cmd          (cmd_in)
    );

    ddrc_cmdq u_cmdq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (cmd_push),
        .i_data (cmd_in),
        .o_full (full),
        .i_pop  (cmd_pop),
        .o_empty(cmd_empty),
        .o_data (cmd_out)
    );

    ddrc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!cmd_empty),
        .i_cmd       (cmd_out),
        .o_cmd_pop   (cmd_pop),
        .i_turn_speed(r_cfg.turn_speed),
        .i_out_space2(out_space2),
        .o_push_cnt  (push_cnt),
        .o_res0      (res0),
        .o_res1      (res1)
    );

    ddrc_outq u_outq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push_cnt(push_cnt),
        .i_data0   (res0),
        .i_data1   (res1),
        .o_space2  (out_space2),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_data    (res_out)
    );

    assign o_right_dir  = res_out.right_dir;
    assign o_right_duty = res_out.right_duty;
    assign o_left_dir   = res_out.left_dir;
    assign o_left_duty  = res_out.left_duty;
    assign o_last       = res_out.last;

endmodule

// ===== hw/rtl/ddrc_checker.sv =====
// Port-level checks for the differential drive ramp controller, bound to the top level.
// Depends on ddrc_pkg and differential_drive_ramp_controller_unit.
module ddrc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [1:0] o_right_dir,
    input logic [7:0] o_right_duty,
    input logic [1:0] o_left_dir,
    input logic [7:0] o_left_duty,
    input logic       o_last
);
    import ddrc_pkg::*;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("Queues are not empty after reset.");

    a_duty_matches_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ((o_right_dir == DIR_STBY) == (o_right_duty == 8'd0)) &&
                   ((o_left_dir == DIR_STBY) == (o_left_duty == 8'd0)))
        else $error("Duty and direction of a result disagree.");

    a_first_is_standby: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_last |-> o_right_dir == DIR_STBY && o_left_dir == DIR_STBY)
        else $error("A result that is not last is not a standby result.");

    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && !empty && !o_last |=> !empty)
        else $error("The second result of a pair did not follow the first.");

endmodule

bind differential_drive_ramp_controller_unit ddrc_checker u_ddrc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .o_right_dir (o_right_dir),
    .o_right_duty(o_right_duty),
    .o_left_dir  (o_left_dir),
    .o_left_duty (o_left_duty),
    .o_last      (o_last)
);

// ===== bench/ddrc_drive_checker.sv =====
`timescale 1ns / 1ps
// Checker for the differential drive ramp controller: watches the input, result and
// register write channels, predicts the motor results and compares them in order.
// Depends on ddrc_pkg.
module ddrc_drive_checker #(
    parameter int TICK_COUNT_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  logic                            i_full,
    input  logic [1:0]                      i_kind,
    input  logic [7:0]                      i_forward_stick,
    input  logic [7:0]                      i_turn_stick,
    input  logic                            i_empty,
    input  logic                            i_pop,
    input  logic [1:0]                      i_right_dir,
    input  logic [7:0]                      i_right_duty,
    input  logic [1:0]                      i_left_dir,
    input  logic [7:0]                      i_left_duty,
    input  logic                            i_last,
    input  logic                            i_cfg_wr_en,
    input  logic [ddrc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ddrc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_mismatches,
    output int                              o_outstanding
);
    import ddrc_pkg::*;

    t_cfg                       regs;
    logic                       locked;
    logic [TICK_COUNT_BITS-1:0] since_order;
    logic [TICK_COUNT_BITS-1:0] since_ramp;
    int                         target_r;
    int                         target_l;
    int                         speed_r;
    int                         speed_l;
    t_result                    motor_due_q[$];
    int                         mismatches;

    function automatic t_result motor_pair(int rs, int ls);
        t_result res;
        res = RES_STANDBY;
        if (rs > 0) begin
            res.right_dir  = DIR_FWD;
            res.right_duty = 8'(rs);
        end else if (rs < 0) begin
            res.right_dir  = DIR_BACK;
            res.right_duty = 8'(-rs);
        end
        if (ls > 0) begin
            res.left_dir  = DIR_FWD;
            res.left_duty = 8'(ls);
        end else if (ls < 0) begin
            res.left_dir  = DIR_BACK;
            res.left_duty = 8'(-ls);
        end
        return res;
    endfunction

    function automatic int ramp_wheel(int tgt, int spd, logic [TICK_COUNT_BITS-1:0] elapsed);
        int     tgt_mag;
        int     spd_mag;
        longint step_to;
        tgt_mag = (tgt < 0) ? -tgt : tgt;
        spd_mag = (spd < 0) ? -spd : spd;
        if (tgt == spd)
            return spd;
        if (tgt == 0 || spd_mag >= tgt_mag)
            return 0;
        step_to = longint'(spd_mag)
                + ((longint'(elapsed) * longint'(regs.accel_rate)) >>> 16);
        if (step_to > tgt_mag)
            step_to = tgt_mag;
        if (step_to < 10)
            step_to = step_to * 2;
        return (tgt < 0) ? -int'(step_to) : int'(step_to);
    endfunction

    task automatic note_mismatch(input string what, input t_result want, input t_result got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: expected R %0d/%0d L %0d/%0d last %0b, got R %0d/%0d L %0d/%0d last %0b",
                     $time, what, want.right_dir, want.right_duty, want.left_dir,
                     want.left_duty, want.last, got.right_dir, got.right_duty,
                     got.left_dir, got.left_duty, got.last);
    endtask

    always @(posedge i_clk) begin : watch
        int      aim;
        logic    tmo_hit;
        logic    ramp_hit;
        t_result tmo_res;
        t_result ramp_res;
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            regs.speed_max        = RST_SPEED_MAX;
            regs.turn_speed       = RST_TURN_SPEED;
            regs.order_timeout_ms = RST_ORDER_TIMEOUT_MS;
            regs.ramp_interval_ms = RST_RAMP_INTERVAL_MS;
            regs.accel_rate       = RST_ACCEL_RATE;
            locked      = 1'b0;
            since_order = '0;
            since_ramp  = '0;
            target_r    = 0;
            target_l    = 0;
            speed_r     = 0;
            speed_l     = 0;
            mismatches  = 0;
            motor_due_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_SPEED_MAX:        regs.speed_max        = i_cfg_data[7:0];
                    REG_TURN_SPEED:       regs.turn_speed       = i_cfg_data[7:0];
                    REG_ORDER_TIMEOUT_MS: regs.order_timeout_ms = i_cfg_data;
                    REG_RAMP_INTERVAL_MS: regs.ramp_interval_ms = i_cfg_data;
                    REG_ACCEL_RATE:       regs.accel_rate       = i_cfg_data;
                    default: ;
                endcase
            end

            if (i_push && !i_full) begin
                case (i_kind)
                    KIND_ORDER: begin
                        since_order = '0;
                        if (!locked) begin
                            if (i_forward_stick > STICK_HIGH) begin
                                aim = (int'(i_forward_stick) - int'(STICK_CENTRE))
                                    * int'(regs.speed_max) / 128;
                                target_r = aim;
                                target_l = aim;
                            end else if (i_forward_stick < STICK_LOW) begin
                                aim = -(int'(i_forward_stick) * int'(regs.speed_max)
                                        / int'(STICK_CENTRE));
                                target_r = aim;
                                target_l = aim;
                            end else if (i_turn_stick > STICK_HIGH) begin
                                target_r = -int'(regs.turn_speed);
                                target_l = int'(regs.turn_speed);
                            end else if (i_turn_stick < STICK_LOW) begin
                                target_r = int'(regs.turn_speed);
                                target_l = -int'(regs.turn_speed);
                            end
                        end
                    end
                    KIND_LOCK: begin
                        locked = 1'b1;
                        tmo_res = RES_STANDBY;
                        tmo_res.last = 1'b1;
                        motor_due_q.push_back(tmo_res);
                    end
                    KIND_UNLOCK: begin
                        locked = 1'b0;
                    end
                    default: begin
                        if (since_order != '1)
                            since_order = since_order + 1'b1;
                        if (since_ramp != '1)
                            since_ramp = since_ramp + 1'b1;
                        tmo_hit  = since_order > regs.order_timeout_ms;
                        ramp_hit = since_ramp > regs.ramp_interval_ms;
                        tmo_res  = RES_STANDBY;
                        if (tmo_hit) begin
                            target_r = 0;
                            target_l = 0;
                        end
                        if (ramp_hit) begin
                            speed_r    = ramp_wheel(target_r, speed_r, since_ramp);
                            speed_l    = ramp_wheel(target_l, speed_l, since_ramp);
                            since_ramp = '0;
                            ramp_res   = motor_pair(speed_r, speed_l);
                            ramp_res.last = 1'b1;
                        end else begin
                            tmo_res.last = 1'b1;
                        end
                        if (tmo_hit)
                            motor_due_q.push_back(tmo_res);
                        if (ramp_hit)
                            motor_due_q.push_back(ramp_res);
                    end
                endcase
            end

            if (i_pop && !i_empty) begin
                got = '{right_dir: i_right_dir, right_duty: i_right_duty,
                        left_dir: i_left_dir, left_duty: i_left_duty, last: i_last};
                if (motor_due_q.size() == 0) begin
                    note_mismatch("result with nothing expected", '0, got);
                end else begin
                    want = motor_due_q.pop_front();
                    if (got.right_dir !== want.right_dir || got.right_duty !== want.right_duty
                        || got.left_dir !== want.left_dir || got.left_duty !== want.left_duty
                        || got.last !== want.last)
                        note_mismatch("result mismatch", want, got);
                end
            end
        end
        o_mismatches  <= mismatches;
        o_outstanding <= motor_due_q.size();
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the differential drive ramp controller: clock, reset, stimulus,
// result stalls and the verdict. Depends on ddrc_pkg, the block and ddrc_drive_checker.
module tb_top;
    import ddrc_pkg::*;

    localparam int TICK_COUNT_BITS = 16;
    localparam int ITEMS_PER_PHASE = 320;
    localparam int SETTLE_CYCLES   = 16;
    localparam int LIMIT_CYCLES    = 1000000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  push;
    logic                  full;
    logic [1:0]            i_kind;
    logic [7:0]            i_forward_stick;
    logic [7:0]            i_turn_stick;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [1:0]            o_right_dir;
    logic [7:0]            o_right_duty;
    logic [1:0]            o_left_dir;
    logic [7:0]            o_left_duty;
    logic                  o_last;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int mismatches;
    int outstanding;
    int cycles       = 0;
    int push_gap_max = 16;
    int pop_gap_max  = 16;
    int pop_wait     = 0;

    always #2 i_clk = ~i_clk;

    differential_drive_ramp_controller_unit #(
        .TICK_COUNT_BITS(TICK_COUNT_BITS)
    ) DUT (.*);

    ddrc_drive_checker #(
        .TICK_COUNT_BITS(TICK_COUNT_BITS)
    ) u_drive_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_full          (full),
        .i_kind          (i_kind),
        .i_forward_stick (i_forward_stick),
        .i_turn_stick    (i_turn_stick),
        .i_empty         (empty),
        .i_pop           (pop),
        .i_right_dir     (o_right_dir),
        .i_right_duty    (o_right_duty),
        .i_left_dir      (o_left_dir),
        .i_left_duty     (o_left_duty),
        .i_last          (o_last),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_mismatches    (mismatches),
        .o_outstanding   (outstanding)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin : result_stall
        int stall;
        if (!i_rst_n) begin
            pop      <= 1'b0;
            pop_wait <= 0;
        end else if (pop && !empty) begin
            if ($urandom_range(0, 31) == 0)
                pop_gap_max = ($urandom_range(0, 1) != 0) ? 16 : 0;
            stall = $urandom_range(0, pop_gap_max);
            pop      <= (stall == 0);
            pop_wait <= stall;
        end else if (pop_wait > 1) begin
            pop_wait <= pop_wait - 1;
        end else begin
            pop_wait <= 0;
            pop      <= 1'b1;
        end
    end

    function automatic logic [7:0] pick_stick();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(151, 255));
            1:       return 8'($urandom_range(0, 99));
            2:       return 8'($urandom_range(100, 150));
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_item(input logic [1:0] kind, input logic [7:0] fwd,
                             input logic [7:0] turn);
        int gap;
        gap = $urandom_range(0, push_gap_max);
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push            <= 1'b1;
        i_kind          <= kind;
        i_forward_stick <= fwd;
        i_turn_stick    <= turn;
        do @(posedge i_clk); while (full);
    endtask

    task automatic drain_results();
        push <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [7:0] smax, input logic [7:0] tspd,
                                input logic [15:0] tmo, input logic [15:0] ivl,
                                input logic [15:0] rate);
        reg_write(REG_SPEED_MAX, {8'($urandom), smax});
        reg_write(REG_TURN_SPEED, {8'($urandom), tspd});
        reg_write(REG_ORDER_TIMEOUT_MS, tmo);
        reg_write(REG_RAMP_INTERVAL_MS, ivl);
        reg_write(REG_ACCEL_RATE, rate);
        reg_write(CFG_IDX_W'($urandom_range(5, 7)), CFG_DATA_W'($urandom));
        i_cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int roll;
        push            <= 1'b0;
        i_kind          <= KIND_TICK;
        i_forward_stick <= STICK_CENTRE;
        i_turn_stick    <= STICK_CENTRE;
        i_cfg_wr_en     <= 1'b0;
        i_cfg_index     <= '0;
        i_cfg_data      <= '0;
        i_rst_n         <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Short timeout and ramp interval so that every case shows up in a few items.
        program_regs(8'hFF, 8'hFF, 16'd4, 16'd1, 16'hFFFF);
        send_item(KIND_ORDER, 8'd255, 8'd0);
        send_item(KIND_TICK, 8'd0, 8'd255);
        send_item(KIND_TICK, 8'd255, 8'd0);
        send_item(KIND_ORDER, 8'd0, 8'd255);
        send_item(KIND_TICK, 8'd127, 8'd127);
        send_item(KIND_TICK, 8'd127, 8'd127);
        send_item(KIND_ORDER, 8'd99, STICK_CENTRE);
        send_item(KIND_TICK, 8'd127, 8'd127);
        send_item(KIND_TICK, 8'd127, 8'd127);
        send_item(KIND_ORDER, 8'd151, STICK_CENTRE);
        send_item(KIND_TICK, 8'd127, 8'd127);
        send_item(KIND_TICK, 8'd127, 8'd127);
        send_item(KIND_ORDER, 8'd150, 8'd151);
        send_item(KIND_TICK, 8'd127, 8'd127);
        send_item(KIND_TICK, 8'd127, 8'd127);
        send_item(KIND_ORDER, 8'd100, 8'd99);
        send_item(KIND_ORDER, STICK_CENTRE, 8'd150);
        send_item(KIND_TICK, 8'd127, 8'd127);
        send_item(KIND_TICK, 8'd127, 8'd127);
        send_item(KIND_LOCK, 8'd127, 8'd127);
        send_item(KIND_ORDER, 8'd255, 8'd255);
        send_item(KIND_UNLOCK, 8'd127, 8'd127);
        repeat (5) send_item(KIND_TICK, 8'd127, 8'd127);
        drain_results();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: program_regs(RST_SPEED_MAX, RST_TURN_SPEED, RST_ORDER_TIMEOUT_MS,
                                RST_RAMP_INTERVAL_MS, RST_ACCEL_RATE);
                1: program_regs(8'd0, 8'd0, 16'd0, 16'd0, 16'd0);
                2: program_regs(8'hFF, 8'hFF, 16'd40, 16'd3, 16'hFFFF);
                default: program_regs(8'($urandom), 8'($urandom),
                                      16'($urandom_range(2, 60)),
                                      16'($urandom_range(0, 12)), 16'($urandom));
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(0, 63) == 0)
                    push_gap_max = ($urandom_range(0, 1) != 0) ? 16 : 0;
                if ($urandom_range(0, 199) == 0)
                    drain_results();
                roll = $urandom_range(0, 99);
                if (roll < 58)
                    send_item(KIND_TICK, 8'($urandom), 8'($urandom));
                else if (roll < 88)
                    send_item(KIND_ORDER, pick_stick(), pick_stick());
                else if (roll < 93)
                    send_item(KIND_LOCK, 8'($urandom), 8'($urandom));
                else
                    send_item(KIND_UNLOCK, 8'($urandom), 8'($urandom));
            end
            drain_results();
        end

        if (mismatches == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
